@@ src/sobel_pkg.sv @@
// shared types and constants for the sobel edge magnitude block
package sobel_pkg;

  localparam int PixW    = 16;
  localparam int WidthW  = 13;
  localparam int HeightW = 16;
  localparam int PendW   = 13;
  localparam int GradW   = 19;  // abs gradient, up to 4*65535
  localparam int SqW     = 39;  // sum of two squares
  localparam int RootW   = 20;

  localparam logic [0:0] CFG_WIDTH  = 1'b0;
  localparam logic [0:0] CFG_HEIGHT = 1'b1;

  localparam logic FUNC_PIXEL = 1'b0;
  localparam logic FUNC_FLUSH = 1'b1;

  typedef struct packed {
    logic            func;
    logic [PixW-1:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [PixW-1:0] edge_value;
    logic            end_of_row;
    logic            end_of_frame;
  } out_item_t;

  // one 3x3 window job handed from front to back
  typedef struct packed {
    logic [PixW-1:0] l0, l1, l2, c0, c1, c2, r0, r1, r2;
    logic            end_of_row;
    logic            end_of_frame;
  } job_t;

endpackage

@@ src/sobel_front.sv @@
// front part: row stores, window and frame position; no new item is taken while one is in work
module sobel_front #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  sobel_pkg::in_item_t         in_item,
  input  logic                        cfg_we,
  input  logic [0:0]                  cfg_index,
  input  logic [sobel_pkg::HeightW-1:0] cfg_data,
  output logic                        job_valid,
  input  logic                        job_full,
  output sobel_pkg::job_t             job
);
  import sobel_pkg::*;

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = $clog2(MAX_WIDTH + 1);

  typedef enum logic [1:0] {
    S_TAKE = 2'b01,
    S_WORK = 2'b10
  } fstate_t;

  fstate_t state;

  logic [PixW-1:0] older_mem [MAX_WIDTH];
  logic [PixW-1:0] newer_mem [MAX_WIDTH];
  logic [PixW-1:0] older_rd, newer_rd;

  logic [WidthW-1:0]  image_width;
  logic [HeightW-1:0] image_height;
  logic [CW-1:0]      column_position;
  logic [HeightW-1:0] row_position;
  logic [PendW-1:0]   pending_results;
  logic [PixW-1:0]    win [6];
  logic               cur_func;
  logic [PixW-1:0]    cur_pix;
  logic [PixW-1:0]    first_pix;  // column 0 of row 0, fills the window of a one-row frame

  // effective sizes
  logic [CW-1:0] w_eff;
  logic [HeightW-1:0] h_eff;
  always_comb begin
    if (image_width == '0) w_eff = CW'(1);
    else if ({1'b0, image_width} > (WidthW+1)'(MAX_WIDTH)) w_eff = CW'(MAX_WIDTH);
    else w_eff = CW'(image_width);
    h_eff = (image_height == '0) ? HeightW'(1) : image_height;
  end

  logic [CW-1:0] cp;
  assign cp = (column_position < w_eff) ? column_position : w_eff - CW'(1);

  // front accepts when idle, the queue has space and no config write is under way
  assign in_stall = (state != S_TAKE) || job_full || cfg_we;

  logic take;
  assign take = in_valid && !in_stall;

  // store read address: current column
  logic [AW-1:0] rd_addr;
  assign rd_addr = cp[AW-1:0];

  always_ff @(posedge clk) begin
    older_rd <= older_mem[rd_addr];
    newer_rd <= newer_mem[rd_addr];
  end

  // decode of the item in work
  logic [PixW-1:0] col0, col1, col2;
  logic is_pix, is_flush, do_job, do_write;
  logic [PixW-1:0] m_l0, m_l1, m_l2, m_c0, m_c1, m_c2, m_r0, m_r1, m_r2;
  logic eor, eof;
  always_comb begin
    is_pix   = (state == S_WORK) && cur_func == FUNC_PIXEL
               && pending_results == '0;
    is_flush = (state == S_WORK) && cur_func == FUNC_FLUSH
               && pending_results != '0;
    col0 = (row_position == '0 && is_pix) ? cur_pix : older_rd;
    col1 = is_pix ? ((row_position == '0) ? cur_pix : newer_rd) : newer_rd;
    col2 = is_pix ? cur_pix : newer_rd;
    do_write = is_pix;
    m_l0 = win[0]; m_l1 = win[1]; m_l2 = win[2];
    m_c0 = win[3]; m_c1 = win[4]; m_c2 = win[5];
    m_r0 = col0;   m_r1 = col1;   m_r2 = col2;
    eor = 1'b0; eof = 1'b0;
    do_job = 1'b0;
    if (is_flush && pending_results == PendW'(1)) begin
      do_job = 1'b1; eor = 1'b1; eof = 1'b1;
      m_r0 = win[3]; m_r1 = win[4]; m_r2 = win[5];
    end else if (is_flush || (is_pix && row_position != '0)) begin
      if (cp == '0) begin
        do_job = is_flush ? (h_eff >= HeightW'(2)) : (row_position >= HeightW'(2));
        eor = 1'b1;
        m_r0 = win[3]; m_r1 = win[4]; m_r2 = win[5];
      end else begin
        do_job = 1'b1;
      end
    end
  end

  assign job_valid = do_job;
  assign job = '{l0: m_l0, l1: m_l1, l2: m_l2, c0: m_c0, c1: m_c1, c2: m_c2,
                 r0: m_r0, r1: m_r1, r2: m_r2, end_of_row: eor, end_of_frame: eof};

  // row stores written in the work cycle
  always_ff @(posedge clk) begin
    if (do_write) begin
      older_mem[cp[AW-1:0]] <= (row_position == '0) ? cur_pix : newer_rd;
      newer_mem[cp[AW-1:0]] <= cur_pix;
    end
  end

  // first pixel of the frame
  always_ff @(posedge clk) begin
    if (is_pix && row_position == '0 && cp == '0) first_pix <= cur_pix;
  end

  // control and window
  logic [CW-1:0] cp_inc;
  assign cp_inc = cp + CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_TAKE;
      image_width <= WidthW'(4096);
      image_height <= HeightW'(1024);
      column_position <= '0;
      row_position <= '0;
      pending_results <= '0;
      for (int k = 0; k < 6; k++) win[k] <= '0;
    end else if (cfg_we) begin
      if (cfg_index == CFG_WIDTH) image_width <= cfg_data[WidthW-1:0];
      else image_height <= cfg_data;
      column_position <= '0;
      row_position <= '0;
      pending_results <= '0;
      state <= S_TAKE;
      for (int k = 0; k < 6; k++) win[k] <= '0;
    end else begin
      case (state)
        S_TAKE: begin
          if (take) begin
            cur_func <= in_item.func;
            cur_pix <= PixW'(in_item.pixel_value[PIXEL_BITS-1:0]);
            state <= S_WORK;
          end
        end
        S_WORK: begin
          state <= S_TAKE;
          if (is_flush && pending_results == PendW'(1)) begin
            column_position <= '0;
            row_position <= '0;
            pending_results <= '0;
            for (int k = 0; k < 6; k++) win[k] <= '0;
          end else if (is_flush) begin
            if (cp == '0) begin
              win[0] <= col0; win[1] <= col1; win[2] <= col2;
            end else begin
              win[0] <= win[3]; win[1] <= win[4]; win[2] <= win[5];
            end
            win[3] <= col0; win[4] <= col1; win[5] <= col2;
            column_position <= cp_inc;
            pending_results <= pending_results - PendW'(1);
          end else if (is_pix) begin
            if (row_position != '0) begin
              if (cp == '0) begin
                win[0] <= col0; win[1] <= col1; win[2] <= col2;
              end else begin
                win[0] <= win[3]; win[1] <= win[4]; win[2] <= win[5];
              end
              win[3] <= col0; win[4] <= col1; win[5] <= col2;
            end
            if (cp_inc >= w_eff) begin
              if (row_position + HeightW'(1) >= h_eff) begin
                row_position <= '0;
                pending_results <= (h_eff >= HeightW'(2)) ? PendW'(w_eff) + PendW'(1)
                                                          : PendW'(w_eff);
                if (h_eff == HeightW'(1)) begin
                  column_position <= CW'(1);
                  for (int k = 0; k < 6; k++) win[k] <= (cp == '0) ? cur_pix : first_pix;
                end else begin
                  column_position <= '0;
                end
              end else begin
                row_position <= row_position + HeightW'(1);
                column_position <= '0;
              end
            end else begin
              column_position <= cp_inc;
            end
          end
        end
        default: state <= S_TAKE;
      endcase
    end
  end

endmodule

@@ src/sobel_queue.sv @@
// short job queue between front and back
module sobel_queue (
  input  logic            clk,
  input  logic            rst,
  input  logic            wr_valid,
  output logic            full,
  input  sobel_pkg::job_t wr_job,
  output logic            rd_valid,
  input  logic            rd_take,
  output sobel_pkg::job_t rd_job
);
  import sobel_pkg::*;

  job_t       slot [4];
  logic [1:0] wp, rp;
  logic [2:0] count;

  // full kept one early so an item in work always has room
  assign full = count >= 3'd3;
  assign rd_valid = count != '0;
  assign rd_job = slot[rp];

  always_ff @(posedge clk) begin
    if (wr_valid) slot[wp] <= wr_job;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp <= '0; rp <= '0; count <= '0;
    end else begin
      if (wr_valid) wp <= wp + 2'd1;
      if (rd_take) rp <= rp + 2'd1;
      count <= count + 3'(wr_valid) - 3'(rd_take);
    end
  end

endmodule

@@ src/sobel_back.sv @@
// back part: gradients, squares, pipelined square root and output register
module sobel_back (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 job_valid,
  output logic                 job_take,
  input  sobel_pkg::job_t      job,
  output logic                 out_valid,
  input  logic                 out_stall,
  output sobel_pkg::out_item_t out_item
);
  import sobel_pkg::*;

  localparam int Steps = RootW;  // one root bit per step

  // pipeline advances when the output is free
  logic adv;
  assign adv = !out_valid || !out_stall;
  assign job_take = job_valid && adv;

  // gradients
  logic [GradW-1:0] ax, ay;
  logic [1:0] fl1;
  logic v1;
  logic signed [GradW:0] gx, gy;
  always_comb begin
    gy = $signed({2'b0, job.l0}) + $signed({1'b0, job.c0, 1'b0}) + $signed({2'b0, job.r0})
       - $signed({2'b0, job.l2}) - $signed({1'b0, job.c2, 1'b0}) - $signed({2'b0, job.r2});
    gx = $signed({2'b0, job.l0}) + $signed({1'b0, job.l1, 1'b0}) + $signed({2'b0, job.l2})
       - $signed({2'b0, job.r0}) - $signed({1'b0, job.r1, 1'b0}) - $signed({2'b0, job.r2});
  end

  // squares, one multiplier each
  logic [SqW-1:0] sq;
  logic [1:0] fl2;
  logic v2;

  // square root stages
  logic [SqW-1:0]   rem  [Steps+1];
  logic [RootW-1:0] root [Steps+1];
  logic [1:0]       fls  [Steps+1];
  logic             vs   [Steps+1];

  always_ff @(posedge clk) begin
    if (adv) begin
      ax <= gx[GradW] ? GradW'(-gx) : gx[GradW-1:0];
      ay <= gy[GradW] ? GradW'(-gy) : gy[GradW-1:0];
      fl1 <= {job.end_of_row, job.end_of_frame};
      sq <= SqW'(ax * ax) + SqW'(ay * ay);
      fl2 <= fl1;
    end
  end

  assign rem[0] = sq;
  assign root[0] = '0;
  assign fls[0] = fl2;
  assign vs[0] = v2;

  for (genvar i = 0; i < Steps; i++) begin : g_root
    localparam int Sh = 2 * (Steps - 1 - i);
    logic [SqW+1:0] trial;
    always_comb trial = ({2'b0, rem[i]} >> Sh) - (SqW+2)'({root[i], 2'b01});
    always_ff @(posedge clk) begin
      if (adv) begin
        if (!trial[SqW+1]) begin
          rem[i+1]  <= rem[i] - (SqW'({root[i], 2'b01}) << Sh);
          root[i+1] <= {root[i][RootW-2:0], 1'b1};
        end else begin
          rem[i+1]  <= rem[i];
          root[i+1] <= {root[i][RootW-2:0], 1'b0};
        end
        fls[i+1] <= fls[i];
      end
    end
    always_ff @(posedge clk) begin
      if (rst) vs[i+1] <= 1'b0;
      else if (adv) vs[i+1] <= vs[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0; v2 <= 1'b0;
    end else if (adv) begin
      v1 <= job_valid; v2 <= v1;
    end
  end

  // output register
  assign out_valid = vs[Steps];
  assign out_item = '{
    edge_value: (root[Steps] > RootW'(16'hffff)) ? 16'hffff : root[Steps][PixW-1:0],
    end_of_row: fls[Steps][1],
    end_of_frame: fls[Steps][0]};

endmodule

@@ src/sobel_3x3_edge_magnitude_top.sv @@
// top level of the sobel 3x3 edge magnitude block
// Pixels enter in raster order and each gives the 3x3 Sobel magnitude of the pixel one row
// and one column behind it, clamped to 16 bits, with borders replicated; flush items drain
// the last row after a frame. The front part takes a new item only after the last one is
// worked, since each update waits for the row store read before it; results leave through
// a job queue and a fixed 22-stage back pipeline (gradients, squares, one root bit per stage).
module sobel_3x3_edge_magnitude_top #(
  parameter int MAX_WIDTH  = 4096,
  parameter int PIXEL_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  sobel_pkg::in_item_t           in_item,
  output logic                          out_valid,
  input  logic                          out_stall,
  output sobel_pkg::out_item_t          out_item,
  input  logic                          cfg_we,
  input  logic [0:0]                    cfg_index,
  input  logic [sobel_pkg::HeightW-1:0] cfg_data
);
  import sobel_pkg::*;

  logic job_valid, job_full, q_valid, q_take;
  job_t job, q_job;

  sobel_front #(.MAX_WIDTH(MAX_WIDTH), .PIXEL_BITS(PIXEL_BITS)) u_front (
    .clk, .rst, .in_valid, .in_stall, .in_item, .cfg_we, .cfg_index, .cfg_data,
    .job_valid, .job_full, .job);

  sobel_queue u_queue (
    .clk, .rst, .wr_valid(job_valid), .full(job_full), .wr_job(job),
    .rd_valid(q_valid), .rd_take(q_take), .rd_job(q_job));

  sobel_back u_back (
    .clk, .rst, .job_valid(q_valid), .job_take(q_take), .job(q_job),
    .out_valid, .out_stall, .out_item);

endmodule

@@ src/sobel_checker.sv @@
// port checker for the sobel edge magnitude top level
module sobel_checker (
  input logic                 clk,
  input logic                 rst,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input sobel_pkg::out_item_t out_item,
  input logic                 cfg_we
);
  import sobel_pkg::*;

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_item)) else $error("result dropped");

  // a frame end is also a row end
  a_eof: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.end_of_frame |-> out_item.end_of_row) else $error("eof without eor");

  // no item accepted during a config write
  a_cfg: assert property (@(posedge clk) disable iff (rst)
    cfg_we |-> in_stall) else $error("accept during config");

  // front never accepts two items in consecutive cycles
  a_gap: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall) else $error("back to back accept");

endmodule

bind sobel_3x3_edge_magnitude_top sobel_checker u_checker (
  .clk, .rst, .in_valid, .in_stall, .out_valid, .out_stall, .out_item, .cfg_we);
